>>> design/ltsk_pkg.sv
// ----------------------------------------------------------------------------
// ltsk_pkg
// Shared widths, lane mapping, register indexes and inter-stage types for the
// linear triangle stiffness core.
// ----------------------------------------------------------------------------
package ltsk_pkg;

   // Field widths
   localparam int COORD_W     = 16;               // Q4.12 vertex coordinate
   localparam int K_W         = 16;               // Q4.12 conductivity
   localparam int CSR_IDX_W   = 2;
   localparam int ENTRY_W     = 32;               // Q16.16 matrix entry

   // Internal datapath widths
   localparam int DIFF_W      = COORD_W + 1;      // edge difference b, c
   localparam int PROD_W      = 2 * DIFF_W - 1;   // b_i*b_j, cross products
   localparam int SCALED_W    = PROD_W + K_W;     // conductivity * product
   localparam int NSUM_W      = SCALED_W + 1;     // numerator N
   localparam int DET_W       = PROD_W + 1;       // twice the signed area
   localparam int DEN_W       = DET_W - 1;        // |det|
   localparam int DIVISOR_W   = DEN_W + 1;        // 2*|det|
   localparam int NUMER_SHIFT = 4;                // 16*|N| = 2 * 8 * |N|
   localparam int NUMER_W     = NSUM_W + NUMER_SHIFT;
   localparam int QUOT_W      = ENTRY_W;
   localparam int HEAD_W      = NUMER_W - QUOT_W;
   localparam int DIV_STEPS   = QUOT_W;           // one quotient bit per stage

   // The matrix is symmetric: six distinct entries, one divider lane each
   localparam int NUM_LANES   = 6;
   localparam int LANE_00     = 0;
   localparam int LANE_01     = 1;
   localparam int LANE_02     = 2;
   localparam int LANE_11     = 3;
   localparam int LANE_12     = 4;
   localparam int LANE_22     = 5;
   localparam int LANE_ROW [NUM_LANES] = '{0, 0, 0, 1, 1, 2};
   localparam int LANE_COL [NUM_LANES] = '{0, 1, 2, 1, 2, 2};

   // Register file
   localparam logic [CSR_IDX_W-1:0] CSR_CONDUCTIVITY_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CONDUCTIVITY_Y = CSR_IDX_W'(1);
   localparam logic [K_W-1:0]       CONDUCTIVITY_ONE   = K_W'(4096);

   // Saturation limits
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
   localparam logic [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

   typedef struct packed {
      logic                                valid;
      logic                                degenerate;
      logic [DIVISOR_W-1:0]                divisor;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0][NUMER_W-1:0]   numer;
   } geom_out_type;

   typedef struct packed {
      logic                                degenerate;
      logic [NUM_LANES-1:0][ENTRY_W-1:0]   entry;
   } result_type;

endpackage

>>> design/linear_triangle_stiffness_core.sv
// ----------------------------------------------------------------------------
// linear_triangle_stiffness_core
// Element stiffness matrix of a linear (P1) triangle:
// K[i][j] = (kx*b_i*b_j + ky*c_i*c_j) / (2*|det|), Q16.16, saturated.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  three vertices, signed Q4.12
//   rsp_      out        rsp_valid / rsp_ready  nine Q16.16 entries, degenerate
//   csr_      in         csr_write_en           csr_index, csr_wdata (16 bit)
//
// One item enters per cycle while req_ready is high. The divider takes one
// quotient bit per stage over 32 stages plus an overflow stage, behind five
// front stages and the output register. Reset clears all valid bits and sets
// both conductivities to 1.0. When rsp_ready is low the output register
// holds and a skid entry catches the item already in flight; req_ready then
// drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
module linear_triangle_stiffness_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_x_first,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_y_first,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_x_second,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_y_second,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_x_third,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  req_y_third,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_00,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_01,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_02,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_10,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_11,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_12,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_20,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_21,
   output logic signed [ltsk_pkg::ENTRY_W-1:0]  rsp_k_22,
   output logic                                 rsp_degenerate,

   input  logic                                 csr_write_en,
   input  logic [ltsk_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ltsk_pkg::K_W-1:0]             csr_wdata
);
   import ltsk_pkg::*;

   logic [K_W-1:0] cond_x_ff, cond_x_in;
   logic [K_W-1:0] cond_y_ff, cond_y_in;
   logic           advance;
   geom_out_type   geom_out;
   logic           div_valid;
   result_type     div_item;
   result_type     rsp_item;

   // Conductivity registers; writes to unused indexes drop silently
   always_comb begin
      cond_x_in = cond_x_ff;
      cond_y_in = cond_y_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CONDUCTIVITY_X: cond_x_in = csr_wdata;
            CSR_CONDUCTIVITY_Y: cond_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cond_x_ff <= CONDUCTIVITY_ONE;
         cond_y_ff <= CONDUCTIVITY_ONE;
      end else begin
         cond_x_ff <= cond_x_in;
         cond_y_ff <= cond_y_in;
      end
   end

   // Everything advances together; advance is a registered skid status
   assign req_ready = advance;

   ltsk_geom u_geom (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_valid),
      .x_first        (req_x_first),
      .y_first        (req_y_first),
      .x_second       (req_x_second),
      .y_second       (req_y_second),
      .x_third        (req_x_third),
      .y_third        (req_y_third),
      .conductivity_x (cond_x_ff),
      .conductivity_y (cond_y_ff),
      .geom_out       (geom_out)
   );

   ltsk_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .geom_in   (geom_out),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   ltsk_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_item   (div_item),
      .advance   (advance),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   // Symmetric matrix: mirror the six distinct lanes onto nine ports
   assign rsp_k_00       = signed'(rsp_item.entry[LANE_00]);
   assign rsp_k_01       = signed'(rsp_item.entry[LANE_01]);
   assign rsp_k_02       = signed'(rsp_item.entry[LANE_02]);
   assign rsp_k_10       = signed'(rsp_item.entry[LANE_01]);
   assign rsp_k_11       = signed'(rsp_item.entry[LANE_11]);
   assign rsp_k_12       = signed'(rsp_item.entry[LANE_12]);
   assign rsp_k_20       = signed'(rsp_item.entry[LANE_02]);
   assign rsp_k_21       = signed'(rsp_item.entry[LANE_12]);
   assign rsp_k_22       = signed'(rsp_item.entry[LANE_22]);
   assign rsp_degenerate = rsp_item.degenerate;

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_k_00 == '0 && rsp_k_01 == '0 && rsp_k_02 == '0 &&
         rsp_k_11 == '0 && rsp_k_12 == '0 && rsp_k_22 == '0)
      else $error("degenerate item with nonzero entries");

endmodule

>>> design/ltsk_geom.sv
// ----------------------------------------------------------------------------
// ltsk_geom
// Five-stage front end: edge differences, products, conductivity scaling,
// numerator sums and |det|, rounded dividend and divisor per lane.
// ----------------------------------------------------------------------------
module ltsk_geom (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  x_first,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  y_first,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  x_second,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  y_second,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  x_third,
   input  logic signed [ltsk_pkg::COORD_W-1:0]  y_third,
   input  logic        [ltsk_pkg::K_W-1:0]      conductivity_x,
   input  logic        [ltsk_pkg::K_W-1:0]      conductivity_y,
   output ltsk_pkg::geom_out_type               geom_out
);
   import ltsk_pkg::*;

   // Stage 1: differences
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] b_ff [3];
   logic signed [DIFF_W-1:0] c_ff [3];
   logic signed [DIFF_W-1:0] b_in [3];
   logic signed [DIFF_W-1:0] c_in [3];

   // Stage 2: products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] bb_ff [NUM_LANES];
   logic signed [PROD_W-1:0] cc_ff [NUM_LANES];
   logic signed [PROD_W-1:0] bb_in [NUM_LANES];
   logic signed [PROD_W-1:0] cc_in [NUM_LANES];
   logic signed [PROD_W-1:0] da_ff, da_in;
   logic signed [PROD_W-1:0] db_ff, db_in;

   // Stage 3: scaled products, det
   logic                       s3_valid_ff;
   logic signed [SCALED_W-1:0] ax_ff [NUM_LANES];
   logic signed [SCALED_W-1:0] ay_ff [NUM_LANES];
   logic signed [SCALED_W-1:0] ax_in [NUM_LANES];
   logic signed [SCALED_W-1:0] ay_in [NUM_LANES];
   logic signed [DET_W-1:0]    det_ff, det_in;
   logic signed [K_W:0]        kx_s, ky_s;

   // Stage 4: numerator, |det|
   logic                     s4_valid_ff;
   logic signed [NSUM_W-1:0] nsum_ff [NUM_LANES];
   logic signed [NSUM_W-1:0] nsum_in [NUM_LANES];
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     degen_ff, degen_in;
   logic [DET_W-1:0]         det_mag;

   // Stage 5: dividend and divisor
   geom_out_type             out_ff, out_in;
   logic [NUMER_W-1:0]       scaled;
   logic [NUMER_W-1:0]       den_ext;

   always_comb begin
      b_in[0] = DIFF_W'(y_second) - DIFF_W'(y_third);
      b_in[1] = DIFF_W'(y_third)  - DIFF_W'(y_first);
      b_in[2] = DIFF_W'(y_first)  - DIFF_W'(y_second);
      c_in[0] = DIFF_W'(x_third)  - DIFF_W'(x_second);
      c_in[1] = DIFF_W'(x_first)  - DIFF_W'(x_third);
      c_in[2] = DIFF_W'(x_second) - DIFF_W'(x_first);
   end

   // det = (x2-x1)(y3-y1) - (x3-x1)(y2-y1) = c2*b1 - c1*b2
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         bb_in[l] = PROD_W'(b_ff[LANE_ROW[l]]) * PROD_W'(b_ff[LANE_COL[l]]);
         cc_in[l] = PROD_W'(c_ff[LANE_ROW[l]]) * PROD_W'(c_ff[LANE_COL[l]]);
      end
      da_in = PROD_W'(c_ff[2]) * PROD_W'(b_ff[1]);
      db_in = PROD_W'(c_ff[1]) * PROD_W'(b_ff[2]);
   end

   always_comb begin
      kx_s = signed'({1'b0, conductivity_x});
      ky_s = signed'({1'b0, conductivity_y});
      for (int l = 0; l < NUM_LANES; l++) begin
         ax_in[l] = SCALED_W'(kx_s) * SCALED_W'(bb_ff[l]);
         ay_in[l] = SCALED_W'(ky_s) * SCALED_W'(cc_ff[l]);
      end
      det_in = DET_W'(da_ff) - DET_W'(db_ff);
   end

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         nsum_in[l] = NSUM_W'(ax_ff[l]) + NSUM_W'(ay_ff[l]);
      end
      det_mag  = det_ff[DET_W-1] ? unsigned'(DET_W'(-det_ff)) : unsigned'(det_ff);
      den_in   = det_mag[DEN_W-1:0];
      degen_in = (det_ff == '0);
   end

   // Dividend 16*|N| + |det| folds the absolute value into one add/subtract
   always_comb begin
      scaled  = '0;
      den_ext = NUMER_W'(den_ff);
      out_in.valid      = s4_valid_ff;
      out_in.degenerate = degen_ff;
      out_in.divisor    = {den_ff, 1'b0};
      for (int l = 0; l < NUM_LANES; l++) begin
         scaled           = {nsum_ff[l], {NUMER_SHIFT{1'b0}}};
         out_in.neg[l]    = nsum_ff[l][NSUM_W-1];
         out_in.numer[l]  = nsum_ff[l][NSUM_W-1] ? (den_ext - scaled) : (den_ext + scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_ff       <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff     <= b_in;
         c_ff     <= c_in;
         bb_ff    <= bb_in;
         cc_ff    <= cc_in;
         da_ff    <= da_in;
         db_ff    <= db_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         det_ff   <= det_in;
         nsum_ff  <= nsum_in;
         den_ff   <= den_in;
         degen_ff <= degen_in;
      end
   end

   assign geom_out = out_ff;

endmodule

>>> design/ltsk_divider.sv
// ----------------------------------------------------------------------------
// ltsk_divider
// Pipelined restoring divider, six lanes sharing one divisor: an overflow
// stage, then one quotient bit per stage, then rounding-free saturation.
// ----------------------------------------------------------------------------
module ltsk_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  ltsk_pkg::geom_out_type    geom_in,
   output logic                      out_valid,
   output ltsk_pkg::result_type      out_item
);
   import ltsk_pkg::*;

   localparam int LAST = DIV_STEPS;

   logic                                 valid_ff   [LAST+1];
   logic                                 valid_in   [LAST+1];
   logic                                 degen_ff   [LAST+1];
   logic                                 degen_in   [LAST+1];
   logic [DIVISOR_W-1:0]                 divisor_ff [LAST+1];
   logic [DIVISOR_W-1:0]                 divisor_in [LAST+1];
   logic [NUM_LANES-1:0]                 neg_ff     [LAST+1];
   logic [NUM_LANES-1:0]                 neg_in     [LAST+1];
   logic [NUM_LANES-1:0]                 ovf_ff     [LAST+1];
   logic [NUM_LANES-1:0]                 ovf_in     [LAST+1];
   logic [NUM_LANES-1:0][DIVISOR_W-1:0]  rem_ff     [LAST+1];
   logic [NUM_LANES-1:0][DIVISOR_W-1:0]  rem_in     [LAST+1];
   logic [NUM_LANES-1:0][QUOT_W-1:0]     word_ff    [LAST+1];
   logic [NUM_LANES-1:0][QUOT_W-1:0]     word_in    [LAST+1];

   always_comb begin
      logic [HEAD_W-1:0]    head;
      logic [DIVISOR_W:0]   trial;
      logic [DIVISOR_W:0]   diff;
      logic                 fits;

      // Entry stage: quotient of 32 bits fits only if head < divisor
      valid_in[0]   = geom_in.valid;
      degen_in[0]   = geom_in.degenerate;
      divisor_in[0] = geom_in.divisor;
      neg_in[0]     = geom_in.neg;
      for (int l = 0; l < NUM_LANES; l++) begin
         head          = geom_in.numer[l][NUMER_W-1:QUOT_W];
         ovf_in[0][l]  = (DIVISOR_W'(head) >= geom_in.divisor);
         rem_in[0][l]  = DIVISOR_W'(head);
         word_in[0][l] = geom_in.numer[l][QUOT_W-1:0];
      end

      // Shift in one dividend bit, subtract where it fits
      for (int s = 1; s <= LAST; s++) begin
         valid_in[s]   = valid_ff[s-1];
         degen_in[s]   = degen_ff[s-1];
         divisor_in[s] = divisor_ff[s-1];
         neg_in[s]     = neg_ff[s-1];
         ovf_in[s]     = ovf_ff[s-1];
         for (int l = 0; l < NUM_LANES; l++) begin
            trial = {rem_ff[s-1][l], word_ff[s-1][l][QUOT_W-1]};
            diff  = trial - {1'b0, divisor_ff[s-1]};
            fits  = (trial >= {1'b0, divisor_ff[s-1]});
            rem_in[s][l]  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            word_in[s][l] = {word_ff[s-1][l][QUOT_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         degen_ff   <= degen_in;
         divisor_ff <= divisor_in;
         neg_ff     <= neg_in;
         ovf_ff     <= ovf_in;
         rem_ff     <= rem_in;
         word_ff    <= word_in;
      end
   end

   // Saturate to Q16.16, zero everything for a degenerate triangle
   always_comb begin
      logic [QUOT_W-1:0] q;
      logic [ENTRY_W-1:0] sat;

      out_valid           = valid_ff[LAST];
      out_item.degenerate = degen_ff[LAST];
      for (int l = 0; l < NUM_LANES; l++) begin
         q = word_ff[LAST][l];
         if (neg_ff[LAST][l]) begin
            sat = (ovf_ff[LAST][l] || (q > ENTRY_MIN)) ? ENTRY_MIN : ENTRY_W'(-q);
         end else begin
            sat = (ovf_ff[LAST][l] || q[QUOT_W-1]) ? ENTRY_MAX : q;
         end
         out_item.entry[l] = degen_ff[LAST] ? '0 : sat;
      end
   end

   a_degen_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && degen_ff[LAST] |-> divisor_ff[LAST] == '0)
      else $error("degenerate item carries a nonzero divisor");

   a_divisor_even_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !degen_ff[LAST] |-> divisor_ff[LAST] != '0 && !divisor_ff[LAST][0])
      else $error("divisor of a proper triangle is zero or odd");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !ovf_ff[LAST][LANE_00] |->
         rem_ff[LAST][LANE_00] < divisor_ff[LAST])
      else $error("partial remainder reached the divisor");

endmodule

>>> design/ltsk_outbuf.sv
// ----------------------------------------------------------------------------
// ltsk_outbuf
// Output register plus one skid entry; pipeline advance comes from a
// register so rsp_ready never reaches the input side combinationally.
// ----------------------------------------------------------------------------
module ltsk_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ltsk_pkg::result_type    in_item,
   output logic                    advance,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ltsk_pkg::result_type    out_item
);
   import ltsk_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_item_ff, out_item_in;
   result_type skid_item_ff, skid_item_in;
   logic       take;
   logic       out_free;

   always_comb begin
      advance  = !skid_valid_ff;
      take     = in_valid && advance;
      out_free = !out_valid_ff || out_ready;

      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;

      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid entry first
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            if (take) begin
               out_item_in = in_item;
            end
         end
      end else if (take) begin
         // hold the item that was already on its way
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while the output register is empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready))
      else $error("skid entry filled without a stalled output");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stiffness core testbench
// Feeds triangles to linear_triangle_stiffness_core over the req_ handshake and
// checks every 3x3 Q16.16 matrix on the rsp_ side against a bit-exact integer
// model. A directed table covers unit and extreme triangles, both vertex
// orientations, zero-area cases, saturation, rounding ties and the register
// extremes; random triangles follow under several conductivity settings and
// three idling modes, with one long receiver stall and a drain mid-segment.
// ----------------------------------------------------------------------------
module tb;
   import ltsk_pkg::*;

   // Vertex set as it crosses the req_ channel
   typedef struct packed {
      logic signed [COORD_W-1:0] x_first;
      logic signed [COORD_W-1:0] y_first;
      logic signed [COORD_W-1:0] x_second;
      logic signed [COORD_W-1:0] y_second;
      logic signed [COORD_W-1:0] x_third;
      logic signed [COORD_W-1:0] y_third;
   } triangle_type;

   // One element matrix, row-major, index 0 is k_00
   typedef struct packed {
      logic [0:8][ENTRY_W-1:0] k;
      logic                    degenerate;
   } stiffness_type;

   // One row of the directed table: conductivities to run under, the triangle,
   // and the matrix when it is known by inspection
   typedef struct packed {
      logic [K_W-1:0] cond_x;
      logic [K_W-1:0] cond_y;
      triangle_type   shape;
      logic           known;
      stiffness_type  want;
   } directed_row_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
   localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] C_ONE = 16'sd4096;
   localparam logic [K_W-1:0]            G_MAX = 16'd65535;

   localparam logic signed [ENTRY_W-1:0] E_ONE  = 32'sd65536;
   localparam logic signed [ENTRY_W-1:0] E_HALF = 32'sd32768;
   localparam logic signed [ENTRY_W-1:0] E_LSB  = 32'sd1;
   localparam logic signed [ENTRY_W-1:0] E_ZERO = 32'sd0;

   // Right isosceles triangle with unit conductivities, any size or orientation
   localparam stiffness_type UNIT_STIFFNESS = '{
      k: '{E_ONE, -E_HALF, -E_HALF, -E_HALF, E_HALF, E_ZERO, -E_HALF, E_ZERO, E_HALF},
      degenerate: 1'b0};
   localparam stiffness_type ZERO_STIFFNESS = '{k: '0, degenerate: 1'b0};
   localparam stiffness_type FLAT_TRIANGLE  = '{k: '0, degenerate: 1'b1};
   // Every nonzero entry is exactly +-0.5 LSB: rounding goes away from zero
   localparam stiffness_type TIE_X_STIFFNESS = '{
      k: '{E_LSB, -E_LSB, E_ZERO, -E_LSB, E_LSB, E_ZERO, E_ZERO, E_ZERO, E_ZERO},
      degenerate: 1'b0};
   localparam stiffness_type TIE_Y_STIFFNESS = '{
      k: '{E_LSB, E_ZERO, -E_LSB, E_ZERO, E_ZERO, E_ZERO, -E_LSB, E_ZERO, E_LSB},
      degenerate: 1'b0};

   localparam int NUM_DIRECTED = 22;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // unit triangle, both orientations, largest and smallest size
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd0, 16'sd0, C_ONE, 16'sd0, 16'sd0, C_ONE}, 1'b1, UNIT_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd0, 16'sd0, 16'sd0, C_ONE, C_ONE, 16'sd0}, 1'b1, UNIT_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX}, 1'b1, UNIT_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b1, UNIT_STIFFNESS},
      // zero area: coincident points, collinear points, repeated vertex
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FLAT_TRIANGLE},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1, FLAT_TRIANGLE},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, FLAT_TRIANGLE},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MIN, C_MIN, 16'sd0, 16'sd0, C_MAX, C_MAX}, 1'b1, FLAT_TRIANGLE},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd100, 16'sd200, 16'sd100, 16'sd200, -16'sd5000, 16'sd7000},
        1'b1, FLAT_TRIANGLE},
      // long edges over a sliver: saturation on both sides
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, -16'sd32767}, 1'b0, ZERO_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'sd32766}, 1'b0, ZERO_STIFFNESS},
      // coordinate bit extremes and a plain triangle
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{C_MAX, C_MIN, C_MIN, C_MAX, -16'sd1, 16'sd0}, 1'b0, ZERO_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{-16'sd1, C_MAX, C_MIN, -16'sd1, 16'sd0, C_MIN}, 1'b0, ZERO_STIFFNESS},
      '{CONDUCTIVITY_ONE, CONDUCTIVITY_ONE,
        '{16'sd12345, -16'sd2222, -16'sd7000, 16'sd3000, 16'sd500, -16'sd15000},
        1'b0, ZERO_STIFFNESS},
      // zero conductivities: zero matrix, flag still follows the area
      '{16'd0, 16'd0,
        '{16'sd0, 16'sd0, C_ONE, 16'sd0, 16'sd0, C_ONE}, 1'b1, ZERO_STIFFNESS},
      '{16'd0, 16'd0,
        '{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, -16'sd32767}, 1'b1, ZERO_STIFFNESS},
      '{16'd0, 16'd0,
        '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1'b1, FLAT_TRIANGLE},
      // rounding ties through one conductivity at a time
      '{16'd1, 16'd0,
        '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd1}, 1'b1, TIE_X_STIFFNESS},
      '{16'd0, 16'd1,
        '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd16}, 1'b1, TIE_Y_STIFFNESS},
      // largest conductivities
      '{G_MAX, G_MAX,
        '{16'sd0, 16'sd0, C_ONE, 16'sd0, 16'sd0, C_ONE}, 1'b0, ZERO_STIFFNESS},
      '{G_MAX, G_MAX,
        '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'sd32766}, 1'b0, ZERO_STIFFNESS},
      '{G_MAX, 16'd1,
        '{16'sd3001, -16'sd77, -16'sd420, 16'sd9999, 16'sd8, -16'sd31000},
        1'b0, ZERO_STIFFNESS}
   };

   localparam int NUM_SEGMENTS     = 6;
   localparam int SEGMENT_ITEMS    = 64;
   localparam int RSP_HOLD_CYCLES  = 200;   // long receiver stall, fills the pipe
   localparam int SETTLE_CYCLES    = 50;    // longer than the pipeline latency
   localparam int RUN_LIMIT_NS     = 1_000_000;

   logic clock;
   logic reset;

   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_x_first;
   logic signed [COORD_W-1:0] req_y_first;
   logic signed [COORD_W-1:0] req_x_second;
   logic signed [COORD_W-1:0] req_y_second;
   logic signed [COORD_W-1:0] req_x_third;
   logic signed [COORD_W-1:0] req_y_third;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [ENTRY_W-1:0] rsp_k_00, rsp_k_01, rsp_k_02;
   logic signed [ENTRY_W-1:0] rsp_k_10, rsp_k_11, rsp_k_12;
   logic signed [ENTRY_W-1:0] rsp_k_20, rsp_k_21, rsp_k_22;
   logic                      rsp_degenerate;

   logic                      csr_write_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [K_W-1:0]            csr_wdata;

   // Conductivities as the block should hold them
   logic [K_W-1:0] cond_x_now;
   logic [K_W-1:0] cond_y_now;

   // Matrices owed by the block, oldest first
   stiffness_type pending_matrices [$];
   int            error_count;

   // Idling controls for sender and receiver, set by the stimulus process
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   bit          rsp_hold_request;

   string entry_name [9] = '{"k_00", "k_01", "k_02", "k_10", "k_11", "k_12",
                             "k_20", "k_21", "k_22"};

   linear_triangle_stiffness_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_first    (req_x_first),
      .req_y_first    (req_y_first),
      .req_x_second   (req_x_second),
      .req_y_second   (req_y_second),
      .req_x_third    (req_x_third),
      .req_y_third    (req_y_third),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_k_00       (rsp_k_00),
      .rsp_k_01       (rsp_k_01),
      .rsp_k_02       (rsp_k_02),
      .rsp_k_10       (rsp_k_10),
      .rsp_k_11       (rsp_k_11),
      .rsp_k_12       (rsp_k_12),
      .rsp_k_20       (rsp_k_20),
      .rsp_k_21       (rsp_k_21),
      .rsp_k_22       (rsp_k_22),
      .rsp_degenerate (rsp_degenerate),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Exact stiffness matrix: all products in 64-bit integers, then one division
   // per entry with rounding half away from zero and saturation to Q16.16.
   function automatic stiffness_type predict_stiffness(triangle_type t,
                                                       logic [K_W-1:0] gx,
                                                       logic [K_W-1:0] gy);
      longint          b [3];
      longint          c [3];
      longint          x1, y1, x2, y2, x3, y3;
      longint          area2, num;
      longint unsigned den, mag, q;
      logic [63:0]     entry;
      stiffness_type   r;
      x1 = longint'($signed(t.x_first));
      y1 = longint'($signed(t.y_first));
      x2 = longint'($signed(t.x_second));
      y2 = longint'($signed(t.y_second));
      x3 = longint'($signed(t.x_third));
      y3 = longint'($signed(t.y_third));
      b[0] = y2 - y3;
      b[1] = y3 - y1;
      b[2] = y1 - y2;
      c[0] = x3 - x2;
      c[1] = x1 - x3;
      c[2] = x2 - x1;
      area2 = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
      r = ZERO_STIFFNESS;
      if (area2 == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      den = (area2 < 0) ? -area2 : area2;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            num = longint'(gx) * (b[i] * b[j]) + longint'(gy) * (c[i] * c[j]);
            mag = (num < 0) ? -num : num;
            mag = mag * 8;
            q = (2 * mag + den) / (2 * den);
            if (num < 0) begin
               if (q > 64'd2147483648) q = 64'd2147483648;
               entry = -q;
            end else begin
               if (q > 64'd2147483647) q = 64'd2147483647;
               entry = q;
            end
            r.k[i * 3 + j] = entry[ENTRY_W-1:0];
         end
      end
      return r;
   endfunction

   // Random triangle: full-range ones most often, then small ones, exact and near
   // collinear ones, and corners of the coordinate range
   function automatic triangle_type random_triangle();
      int           v [6];
      int           corner [6];
      int           pick, cx, cy, span, dx, dy, m;
      triangle_type t;
      corner = '{-32768, -32767, -1, 0, 1, 32767};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         for (int k = 0; k < 6; k++) v[k] = int'($urandom_range(0, 65535)) - 32768;
      end else if (pick < 65) begin
         cx = int'($urandom_range(0, 60000)) - 30000;
         cy = int'($urandom_range(0, 60000)) - 30000;
         span = 1 << $urandom_range(0, 11);
         for (int k = 0; k < 6; k++)
            v[k] = ((k % 2) ? cy : cx) + int'($urandom_range(0, 2 * span)) - span;
      end else if (pick < 90) begin
         v[0] = int'($urandom_range(0, 32000)) - 16000;
         v[1] = int'($urandom_range(0, 32000)) - 16000;
         dx = int'($urandom_range(0, 16000)) - 8000;
         dy = int'($urandom_range(0, 16000)) - 8000;
         m = int'($urandom_range(0, 4)) - 2;
         v[2] = v[0] + dx;
         v[3] = v[1] + dy;
         v[4] = v[0] + m * dx;
         v[5] = v[1] + m * dy;
         // knock nearly half of these just off the line: tiny area, huge entries
         if (pick >= 78) v[5] = v[5] + ($urandom_range(0, 1) ? 1 : -1);
      end else begin
         for (int k = 0; k < 6; k++) v[k] = corner[$urandom_range(0, 5)];
      end
      t.x_first  = COORD_W'(v[0]);
      t.y_first  = COORD_W'(v[1]);
      t.x_second = COORD_W'(v[2]);
      t.y_second = COORD_W'(v[3]);
      t.x_third  = COORD_W'(v[4]);
      t.y_third  = COORD_W'(v[5]);
      return t;
   endfunction

   // Present one triangle, hold it until accepted, then queue its matrix
   task automatic offer_triangle(input triangle_type t, input logic known,
                                 input stiffness_type want);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_x_first  <= t.x_first;
      req_y_first  <= t.y_first;
      req_x_second <= t.x_second;
      req_y_second <= t.y_second;
      req_x_third  <= t.x_third;
      req_y_third  <= t.y_third;
      do @(posedge clock); while (!req_ready);
      pending_matrices.push_back(known ? want
                                       : predict_stiffness(t, cond_x_now, cond_y_now));
   endtask

   // Drop valid for a random number of cycles, per the current idle rate
   task automatic sender_gap();
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop offering and wait until every owed matrix has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_matrices.size() != 0) @(posedge clock);
   endtask

   // Register write; indexes beyond the two conductivities must be ignored
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [K_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_CONDUCTIVITY_X) cond_x_now = data;
      else if (idx == CSR_CONDUCTIVITY_Y) cond_y_now = data;
   endtask

   task automatic set_conductivities(input logic [K_W-1:0] gx, input logic [K_W-1:0] gy);
      drain_pipeline();
      write_register(CSR_CONDUCTIVITY_X, gx);
      write_register(CSR_CONDUCTIVITY_Y, gy);
   endtask

   // Receiver: stall at random, or hold off for a long counted stretch when asked
   initial begin : rsp_driver
      int unsigned hold_left;
      logic        ready_next;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            hold_left = RSP_HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = ($urandom_range(0, 99) >= rsp_stall_pct);
         end
         rsp_ready <= ready_next;
      end
   end

   // Compare each delivered matrix with the oldest one owed
   always @(posedge clock) begin : matrix_check
      stiffness_type got;
      stiffness_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.k = {rsp_k_00, rsp_k_01, rsp_k_02, rsp_k_10, rsp_k_11, rsp_k_12,
                  rsp_k_20, rsp_k_21, rsp_k_22};
         got.degenerate = rsp_degenerate;
         if (pending_matrices.size() == 0) begin
            $error("matrix delivered with none outstanding");
            error_count++;
         end else begin
            want = pending_matrices.pop_front();
            for (int e = 0; e < 9; e++) begin
               if (got.k[e] !== want.k[e]) begin
                  $error("%s mismatch: expected %0d, actual %0d", entry_name[e],
                         $signed(want.k[e]), $signed(got.k[e]));
                  error_count++;
               end
            end
            if (got.degenerate !== want.degenerate) begin
               $error("degenerate mismatch: expected %0b, actual %0b",
                      want.degenerate, got.degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      triangle_type     shape;
      error_count      = 0;
      rsp_hold_request = 1'b0;
      req_idle_pct     = 35;
      rsp_stall_pct    = 48;
      cond_x_now       = CONDUCTIVITY_ONE;
      cond_y_now       = CONDUCTIVITY_ONE;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_x_first      = '0;
      req_y_first      = '0;
      req_x_second     = '0;
      req_y_second     = '0;
      req_x_third      = '0;
      req_y_third      = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_CONDUCTIVITY_X;
      csr_wdata        = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; rewrite the conductivities only when a row asks for new ones
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.cond_x != cond_x_now || row.cond_y != cond_y_now)
            set_conductivities(row.cond_x, row.cond_y);
         offer_triangle(row.shape, row.known, row.want);
         sender_gap();
      end

      // Random segments: first two with sender gaps lighter than receiver
      // stalls, next two the other way round, last two at full rate
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         drain_pipeline();
         case (seg)
            0: set_conductivities(CONDUCTIVITY_ONE, CONDUCTIVITY_ONE);
            1: begin
               set_conductivities(G_MAX, 16'd0);
               // spare indexes must leave both conductivities alone
               write_register(CSR_SPARE_2, K_W'($urandom));
               write_register(CSR_SPARE_3, K_W'($urandom));
            end
            2: set_conductivities(16'd0, G_MAX);
            3: set_conductivities(K_W'($urandom), K_W'($urandom));
            4: set_conductivities(G_MAX, G_MAX);
            default: set_conductivities(K_W'($urandom_range(1, 15)), K_W'($urandom));
         endcase
         if (seg < 2) begin
            req_idle_pct  = 35;
            rsp_stall_pct = 48;
         end else if (seg < 4) begin
            req_idle_pct  = 48;
            rsp_stall_pct = 35;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         // long receiver stall while the sender keeps pushing: back-pressure
         if (seg == 4) rsp_hold_request = 1'b1;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // halfway through one segment, pause until everything is back
            if (seg == 1 && n == SEGMENT_ITEMS / 2) drain_pipeline();
            shape = random_triangle();
            offer_triangle(shape, 1'b0, ZERO_STIFFNESS);
            sender_gap();
         end
      end

      drain_pipeline();
      // catch any stray late matrix
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/ltsk_pkg.sv
design/ltsk_geom.sv
design/ltsk_divider.sv
design/ltsk_outbuf.sv
design/linear_triangle_stiffness_core.sv
tb/tb.sv
